>>> rtl/core/csl_pkg.sv
// Shared codes, field widths and the result word type for the cursor sequence list.
package csl_pkg;

	// Field widths of the item and result words
	localparam int FUNC_W  = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;
	localparam int ERR_W   = 2;

	// Operation codes; codes above FUNC_READ behave as a read
	localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ATTACH  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd5;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL       = 2'd1;
	localparam logic [ERR_W-1:0] ERR_NO_CURRENT = 2'd2;

	// Result word handed from the sequencer to the output register
	typedef struct packed {
		logic [VALUE_W-1:0] current_value;
		logic               has_current;
		logic [COUNT_W-1:0] entry_count;
		logic [ERR_W-1:0]   error_code;
	} res_t;

endpackage

>>> rtl/core/csl_mem.sv
// Entry store: one write port and one registered read port.
module csl_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one entry; hold the data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/csl_ctrl.sv
// Sequencer: decodes one word, moves entries through the store one per cycle, reads the cursor.
module csl_ctrl
	import csl_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 5,
	parameter int CNT_W      = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [FUNC_W-1:0]     func,
	input  logic [VALUE_W-1:0]    entry_value,
	input  logic                  out_free,
	output logic                  res_load,
	output res_t                  res,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output logic [DATA_WIDTH-1:0] mem_wdata,
	output logic                  mem_re,
	output logic [IDX_W-1:0]      mem_raddr,
	input  logic [DATA_WIDTH-1:0] mem_rdata
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
	localparam logic [IDX_W-1:0] STEP_C = IDX_W'(1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_READ  = 5'b01000,
		ST_LOAD  = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cur_q, cnt_q, left_q;
	logic                 pend_q;
	logic [IDX_W-1:0]     rd_q, wa_q, pos_q;
	logic                 up_q, wr_q;
	logic [ERR_W-1:0]     err_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic                 accept, has, full;
	logic [CNT_W-1:0]     n_cur, n_cnt, n_m, n_rd, n_pos;
	logic                 n_up, n_wr;
	logic [ERR_W-1:0]     n_err;
	logic [63:0]          wv_ext, rd_ext;
	logic [15:0]          cnt_ext;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign has        = (cur_q < cnt_q);
	assign full       = (cnt_q == CAP_C);
	assign wv_ext     = 64'(entry_value);
	assign rd_ext     = 64'(mem_rdata);
	assign cnt_ext    = 16'(cnt_q);

	// Decode the operation against the current cursor and count
	always_comb begin
		n_cur = cur_q;
		n_cnt = cnt_q;
		n_m   = '0;
		n_rd  = '0;
		n_pos = '0;
		n_up  = 1'b0;
		n_wr  = 1'b0;
		n_err = ERR_OK;
		case (func)
			FUNC_START: begin
				n_cur = '0;
			end
			FUNC_ADVANCE: begin
				if (has) begin
					n_cur = cur_q + ONE_C;
				end else begin
					n_err = ERR_NO_CURRENT;
				end
			end
			FUNC_INSERT: begin
				if (full) begin
					n_err = ERR_FULL;
				end else begin
					n_pos = has ? cur_q : '0;
					n_m   = cnt_q - n_pos;
					n_rd  = cnt_q - ONE_C;
					n_up  = 1'b1;
					n_wr  = 1'b1;
					n_cur = n_pos;
					n_cnt = cnt_q + ONE_C;
				end
			end
			FUNC_ATTACH: begin
				if (full) begin
					n_err = ERR_FULL;
				end else begin
					n_pos = has ? (cur_q + ONE_C) : cnt_q;
					n_m   = cnt_q - n_pos;
					n_rd  = cnt_q - ONE_C;
					n_up  = 1'b1;
					n_wr  = 1'b1;
					n_cur = n_pos;
					n_cnt = cnt_q + ONE_C;
				end
			end
			FUNC_REMOVE: begin
				if (has) begin
					n_m   = cnt_q - cur_q - ONE_C;
					n_rd  = cur_q + ONE_C;
					n_cnt = cnt_q - ONE_C;
				end else begin
					n_err = ERR_NO_CURRENT;
				end
			end
			default: begin
				if (!has) begin
					n_err = ERR_NO_CURRENT;
				end
			end
		endcase
	end

	// Drive the store ports and the next state
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = rd_q;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				mem_we = pend_q;
				if (left_q != '0) begin
					mem_re = 1'b1;
				end else begin
					state_d = wr_q ? ST_WRITE : ST_READ;
				end
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
				state_d   = ST_READ;
			end
			ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q[IDX_W-1:0];
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				res_load = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state: sequencer, cursor, count, pending move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cur_q  <= n_cur;
				cnt_q  <= n_cnt;
				left_q <= n_m;
				pend_q <= 1'b0;
			end else if (state_q == ST_SHIFT) begin
				if (left_q != '0) begin
					left_q <= left_q - ONE_C;
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	// Hold the word's operands and advance the move pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q  <= n_rd[IDX_W-1:0];
			pos_q <= n_pos[IDX_W-1:0];
			up_q  <= n_up;
			wr_q  <= n_wr;
			err_q <= n_err;
			val_q <= wv_ext[DATA_WIDTH-1:0];
		end else if ((state_q == ST_SHIFT) && (left_q != '0)) begin
			wa_q <= up_q ? (rd_q + STEP_C) : (rd_q - STEP_C);
			rd_q <= up_q ? (rd_q - STEP_C) : (rd_q + STEP_C);
		end
	end

	// Build the result word from the cursor entry
	assign res.current_value = has ? rd_ext[VALUE_W-1:0] : '0;
	assign res.has_current   = has;
	assign res.entry_count   = cnt_ext[COUNT_W-1:0];
	assign res.error_code    = err_q;

endmodule

>>> rtl/core/cursor_sequence_list.sv
// Top level of the cursor sequence list: sequencer, entry store and output register.
//
// An ordered store of up to CAPACITY entries with a cursor. Each item word on the
// item channel (item_valid / item_stall, fields func and entry_value) carries one
// operation: start, advance, insert before, attach after, remove, or read. Each
// item gives exactly one result word on the result channel (result_valid /
// result_stall): the entry under the cursor, whether it exists, the entry count
// and an error code. A failing operation leaves the store unchanged.
//
// Sequencing: insert, attach and remove move the entries behind the cursor one per
// cycle through the single-port-pair store, m entries in all (at most
// CAPACITY - 1). After the move, insert and attach write the new entry; then the
// entry under the cursor is read and the result is loaded once the output
// register is free, and the idle state after that load takes the next item.
// item_stall is high while an item is being worked on. The result sits in
// an output register, so the next item is accepted while a result still waits; a
// stalled result holds its word and blocks only the loading of the next result.
//
// Reset (arst_n low) empties the store and puts the cursor at the front; entry
// contents are not cleared and no clearing pass runs.
module cursor_sequence_list
	import csl_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [FUNC_W-1:0]  func,
	input  logic [VALUE_W-1:0] entry_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [VALUE_W-1:0] current_value,
	output logic               has_current,
	output logic [COUNT_W-1:0] entry_count,
	output logic [ERR_W-1:0]   error_code
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	logic                  res_load, out_free, result_valid_q;
	res_t                  res, res_q;

	csl_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.func       (func),
		.entry_value(entry_value),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	csl_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_WIDTH),
		.AW   (IDX_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Take a new result word when the register is empty or being drained
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign result_valid  = result_valid_q;
	assign current_value = res_q.current_value;
	assign has_current   = res_q.has_current;
	assign entry_count   = res_q.entry_count;
	assign error_code    = res_q.error_code;

endmodule

>>> dv/cursor_sequence_list_check.sv
// Checker for the cursor sequence list: tracks the list from accepted words and compares results.
module cursor_sequence_list_check
	import csl_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [FUNC_W-1:0]  func,
	input  logic [VALUE_W-1:0] entry_value,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [VALUE_W-1:0] current_value,
	input  logic               has_current,
	input  logic [COUNT_W-1:0] entry_count,
	input  logic [ERR_W-1:0]   error_code,
	output int                 mismatch_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// Shadow copy of the list and its cursor
	logic [VALUE_W-1:0] slots [CAPACITY];
	int held;
	int cursor_pos;

	// Reports still owed by the block, oldest first
	res_t cursor_reports [$];

	// Apply one operation to the shadow list and build the report it should give
	function automatic res_t apply_list_op(input logic [FUNC_W-1:0] op,
			input logic [VALUE_W-1:0] value);
		res_t rep;
		logic [ERR_W-1:0] err;
		int i;
		err = ERR_OK;
		case (op)
			FUNC_START: begin
				cursor_pos = 0;
			end
			FUNC_ADVANCE: begin
				if (cursor_pos < held)
					cursor_pos++;
				else
					err = ERR_NO_CURRENT;
			end
			FUNC_INSERT: begin
				if (held >= CAPACITY) begin
					err = ERR_FULL;
				end else begin
					// with no current entry the new one goes to the front
					if (cursor_pos >= held)
						cursor_pos = 0;
					for (i = held; i > cursor_pos; i--)
						slots[i] = slots[i-1];
					slots[cursor_pos] = value;
					held++;
				end
			end
			FUNC_ATTACH: begin
				if (held >= CAPACITY) begin
					err = ERR_FULL;
				end else begin
					// with no current entry the new one goes to the end
					if (cursor_pos >= held) begin
						cursor_pos = held;
					end else begin
						cursor_pos++;
						for (i = held; i > cursor_pos; i--)
							slots[i] = slots[i-1];
					end
					slots[cursor_pos] = value;
					held++;
				end
			end
			FUNC_REMOVE: begin
				if (cursor_pos < held) begin
					for (i = cursor_pos + 1; i < held; i++)
						slots[i-1] = slots[i];
					held--;
				end else begin
					err = ERR_NO_CURRENT;
				end
			end
			default: begin
				// read, and the unused codes that act as a read
				if (cursor_pos >= held)
					err = ERR_NO_CURRENT;
			end
		endcase
		rep.has_current   = (cursor_pos < held);
		rep.current_value = rep.has_current ? slots[cursor_pos] : '0;
		rep.entry_count   = COUNT_W'(held);
		rep.error_code    = err;
		return rep;
	endfunction

	// Compare accepted results, then predict from accepted words
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			cursor_reports.delete();
			held = 0;
			cursor_pos = 0;
			mismatch_count = 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got.current_value = current_value;
				got.has_current   = has_current;
				got.entry_count   = entry_count;
				got.error_code    = error_code;
				if (cursor_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result word with none pending: value %h cur %b count %0d err %0d",
							$realtime, got.current_value, got.has_current, got.entry_count,
							got.error_code);
				end else begin
					want = cursor_reports.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"%0t: result mismatch: value %h/%h cur %b/%b ",
								"count %0d/%0d err %0d/%0d (expected/actual)"},
								$realtime, want.current_value, got.current_value,
								want.has_current, got.has_current,
								want.entry_count, got.entry_count,
								want.error_code, got.error_code);
					end
				end
			end
			if (item_valid && !item_stall)
				cursor_reports.push_back(apply_list_op(func, entry_value));
			pending <= cursor_reports.size();
		end
	end

endmodule

>>> dv/cursor_sequence_list_test.sv
// Testbench top for the cursor sequence list: clock, reset, stimulus and verdict.
module cursor_sequence_list_test
	import csl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = 32;
	localparam int DATA_WIDTH     = 32;
	localparam int RANDOM_WORDS   = 1750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;

	// Codes beyond read that the block treats as a read
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	// Phase kinds of the random part
	localparam int PHASE_FILL  = 0;
	localparam int PHASE_EMPTY = 1;
	localparam int PHASE_MIX   = 2;

	// Result stall patterns
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_LONG  = 3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [FUNC_W-1:0]  func = FUNC_READ;
	logic [VALUE_W-1:0] entry_value = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [VALUE_W-1:0] current_value;
	logic               has_current;
	logic [COUNT_W-1:0] entry_count;
	logic [ERR_W-1:0]   error_code;

	int mismatch_count;
	int pending;
	int sent_words = 0;
	int burst_left = 0;
	bit valid_hi = 1'b0;
	int idle_cycles = 0;
	int unsigned stall_mode = STALL_NONE;
	int unsigned mode_left = 0;

	cursor_sequence_list #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.func          (func),
		.entry_value   (entry_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.current_value (current_value),
		.has_current   (has_current),
		.entry_count   (entry_count),
		.error_code    (error_code)
	);

	cursor_sequence_list_check #(
		.CAPACITY (CAPACITY)
	) list_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.func           (func),
		.entry_value    (entry_value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.current_value  (current_value),
		.has_current    (has_current),
		.entry_count    (entry_count),
		.error_code     (error_code),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side on a pattern that changes every so often
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(STALL_NONE, STALL_LONG);
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
			default:     result_stall <= ((mode_left % 24) < 16);
		endcase
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cursor_sequence_list test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one word, hold it until accepted, then maybe open a gap
	task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] value);
		item_valid <= 1'b1;
		func <= op;
		entry_value <= value;
		valid_hi = 1'b1;
		do @(posedge clk); while (item_stall);
		sent_words++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			valid_hi = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 8);
		end
	endtask

	// Drop valid and hold off until every pending result has come back
	task automatic wait_results_drained();
		if (valid_hi) begin
			item_valid <= 1'b0;
			valid_hi = 1'b0;
		end
		do @(posedge clk); while (pending != 0);
	endtask

	// Pick an operation, biased toward growing or shrinking the list by phase
	function automatic logic [FUNC_W-1:0] pick_op(input int kind);
		int roll;
		roll = $urandom_range(0, 99);
		if (kind == PHASE_MIX)
			return FUNC_W'($urandom_range(FUNC_START, FUNC_SPARE_HI));
		if (kind == PHASE_FILL) begin
			if (roll < 40) return FUNC_ATTACH;
			if (roll < 70) return FUNC_INSERT;
			if (roll < 80) return FUNC_ADVANCE;
			if (roll < 88) return FUNC_START;
			if (roll < 95) return FUNC_READ;
			if (roll < 98) return FUNC_REMOVE;
			return (roll == 98) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
		end
		if (roll < 45) return FUNC_REMOVE;
		if (roll < 60) return FUNC_ADVANCE;
		if (roll < 70) return FUNC_START;
		if (roll < 80) return FUNC_READ;
		if (roll < 88) return FUNC_INSERT;
		if (roll < 96) return FUNC_ATTACH;
		return (roll < 98) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
	endfunction

	// Mix extreme values in with plain random ones
	function automatic logic [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		if (roll == 2) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
		return $urandom;
	endfunction

	initial begin
		int kind;
		int phase_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: errors on an empty list, unused codes, edges of the cursor
		send_op(FUNC_READ, '0);
		send_op(FUNC_ADVANCE, '0);
		send_op(FUNC_REMOVE, '0);
		send_op(FUNC_START, '1);
		send_op(FUNC_SPARE_LO, '0);
		send_op(FUNC_SPARE_HI, '1);
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_ATTACH, '1);
		send_op(FUNC_ADVANCE, '0);
		send_op(FUNC_READ, '0);
		send_op(FUNC_ATTACH, 32'h8000_0000);
		send_op(FUNC_ADVANCE, '0);
		send_op(FUNC_INSERT, 32'h0000_0001);
		send_op(FUNC_START, '0);
		send_op(FUNC_ADVANCE, '0);
		send_op(FUNC_REMOVE, '0);
		send_op(FUNC_REMOVE, '0);
		send_op(FUNC_REMOVE, '0);
		send_op(FUNC_START, '0);
		send_op(FUNC_REMOVE, '0);
		send_op(FUNC_READ, '0);
		wait_results_drained();

		// Random phases biased to fill the list toward capacity, empty it, or mix freely
		while (sent_words < RANDOM_WORDS) begin
			kind = $urandom_range(PHASE_FILL, PHASE_MIX);
			phase_len = $urandom_range(40, 90);
			repeat (phase_len) send_op(pick_op(kind), pick_value());
			if ($urandom_range(0, 5) == 0)
				wait_results_drained();
		end

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("cursor_sequence_list test passed");
		else
			$display("cursor_sequence_list test failed");
		$finish;
	end

endmodule
